/* hdl/scmt_pkg.sv */
// Shared types and constants for the size-class max tree.
// Used by scmt_walker, size_class_max_tree, the checker and tb; depends on nothing else.
package scmt_pkg;

    localparam int DEF_BUCKETS = 64;
    localparam int BUCKET_W    = 6;
    localparam int OP_W        = 2;

    localparam logic [OP_W-1:0] OP_MARK   = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd1;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [BUCKET_W-1:0] bucket;
    } t_req;

    typedef struct packed {
        logic                idle;
        logic                res_valid;
        logic [BUCKET_W-1:0] res;
    } t_stat;

endpackage

/* hdl/scmt_walker.sv */
// Tree walker: node memory plus the sequencer for mark, clear and search.
// Depends on scmt_pkg.
module scmt_walker
    import scmt_pkg::*;
#(
    parameter int BUCKETS = DEF_BUCKETS
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_req  i_req,
    input  logic  i_res_ready,
    output t_stat o_stat
);

    localparam int NODES     = 2 * BUCKETS - 1;
    localparam int IW        = $clog2(NODES);
    localparam int NW        = $clog2(BUCKETS);
    localparam int CW        = (NW > BUCKET_W) ? NW : BUCKET_W;
    localparam int LEAF_BASE = BUCKETS - 1;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_MARK  = 3'd2;
    localparam logic [2:0] ST_CLR   = 3'd3;
    localparam logic [2:0] ST_ROOT  = 3'd4;
    localparam logic [2:0] ST_DOWN  = 3'd5;
    localparam logic [2:0] ST_RES   = 3'd6;

    logic [NW-1:0] mem [NODES];

    logic [2:0]          r_state, n_state;
    logic [IW-1:0]       r_idx, n_idx;
    logic [NW-1:0]       r_val, n_val;
    logic [CW-1:0]       r_key, n_key;
    logic [BUCKET_W-1:0] r_res, n_res;
    logic [NW-1:0]       r_rd_a, r_rd_b;

    logic          we;
    logic [IW-1:0] wa;
    logic [NW-1:0] wd;
    logic [IW-1:0] ra, rb;

    logic          b_ok;
    logic [IW-1:0] leaf;
    logic [IW-1:0] base;
    logic [IW-1:0] par;
    logic [IW-1:0] sib;
    logic [NW-1:0] cmax;
    logic [IW-1:0] child;
    logic [NW-1:0] cval;

    always_comb begin
        b_ok  = (i_req.bucket != '0) && (32'(i_req.bucket) < 32'(BUCKETS));
        leaf  = IW'(LEAF_BASE) + IW'(i_req.bucket);
        base  = (r_state == ST_IDLE) ? leaf : r_idx;
        par   = (base - IW'(1)) >> 1;
        sib   = base[0] ? (base + IW'(1)) : (base - IW'(1));
        cmax  = (r_val > r_rd_b) ? r_val : r_rd_b;
        if (CW'(r_rd_a) >= r_key) begin
            child = r_idx;
            cval  = r_rd_a;
        end else begin
            child = r_idx + IW'(1);
            cval  = r_rd_b;
        end
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_val   = r_val;
        n_key   = r_key;
        n_res   = r_res;
        we      = 1'b0;
        wa      = r_idx;
        wd      = '0;
        ra      = par;
        rb      = sib;
        unique case (r_state)
            ST_CLEAR: begin
                we = 1'b1;
                if (r_idx == IW'(NODES - 1)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            ST_IDLE: begin
                if (i_start) begin
                    if ((i_req.op == OP_MARK || i_req.op == OP_CLEAR) && b_ok) begin
                        // Write the leaf now; parent and sibling are read alongside.
                        we      = 1'b1;
                        wa      = leaf;
                        wd      = (i_req.op == OP_MARK) ? NW'(i_req.bucket) : '0;
                        n_val   = wd;
                        n_key   = CW'(i_req.bucket);
                        n_idx   = par;
                        n_state = (i_req.op == OP_MARK) ? ST_MARK : ST_CLR;
                    end else if (i_req.op == OP_SEARCH) begin
                        ra      = '0;
                        n_key   = (i_req.bucket == '0) ? CW'(1) : CW'(i_req.bucket);
                        n_state = ST_ROOT;
                    end
                end
            end
            ST_MARK: begin
                if (CW'(r_rd_a) < r_key) begin
                    we    = 1'b1;
                    wd    = NW'(r_key);
                    n_idx = par;
                    if (r_idx == '0) begin
                        n_state = ST_IDLE;
                    end
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_CLR: begin
                // Only ancestors that held the cleared bucket are recomputed.
                if (CW'(r_rd_a) == r_key) begin
                    we    = 1'b1;
                    wd    = cmax;
                    n_val = cmax;
                    n_idx = par;
                    if (r_idx == '0) begin
                        n_state = ST_IDLE;
                    end
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_ROOT: begin
                if (CW'(r_rd_a) < r_key) begin
                    n_res   = '0;
                    n_state = ST_RES;
                end else begin
                    ra      = IW'(1);
                    rb      = IW'(2);
                    n_idx   = IW'(1);
                    n_state = ST_DOWN;
                end
            end
            ST_DOWN: begin
                ra = (child << 1) + IW'(1);
                rb = (child << 1) + IW'(2);
                if (child >= IW'(LEAF_BASE)) begin
                    n_res   = (CW'(cval) >= r_key) ? BUCKET_W'(CW'(cval)) : '0;
                    n_state = ST_RES;
                end else begin
                    n_idx = (child << 1) + IW'(1);
                end
            end
            ST_RES: begin
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
                n_idx   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        r_rd_a <= mem[ra];
        r_rd_b <= mem[rb];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
        r_key <= n_key;
        r_res <= n_res;
    end

    assign o_stat.idle      = (r_state == ST_IDLE);
    assign o_stat.res_valid = (r_state == ST_RES);
    assign o_stat.res       = r_res;

endmodule

/* hdl/size_class_max_tree.sv */
// Top level of the size-class max tree: input and output handshakes.
// Depends on scmt_pkg and scmt_walker.
//
// The block keeps a max tree over BUCKETS size classes in a node memory of
// 2*BUCKETS-1 entries. Each input beat carries an op and a bucket: op mark
// sets the bucket non-empty, op clear sets it empty, op search returns the
// smallest non-empty bucket at or above the request (0 when there is none).
// Only a search produces an output beat; mark, clear and the unused op code
// produce nothing. Bucket 0 is never non-empty.
//
// One item is worked on at a time. A mark or clear writes the leaf in its
// accept cycle, then checks each ancestor in turn, including the one that
// stops the climb, before the next beat is taken. A search reads the root,
// then descends one level per cycle through the memory's two read ports;
// the walker goes back to idle once the output register takes its result.
// A beat the walker ignores (the unused op code, or a mark or clear of
// bucket 0 or of a bucket out of range) frees the block at the next edge.
// The registered read of the node memory sets the per-level cost.
//
// After reset the block sweeps all 2*BUCKETS-1 entries of the node memory
// to zero, one entry a cycle; o_ready stays low during that time. A finished
// search moves into the output register, which frees the walker for the next
// beat. If that register is still full because the receiver holds i_ready
// low, the next result waits in the walker and no beat is taken until the
// register drains.
module size_class_max_tree
    import scmt_pkg::*;
#(
    parameter int BUCKETS = DEF_BUCKETS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [OP_W-1:0]     i_op,
    input  logic [BUCKET_W-1:0] i_bucket,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [BUCKET_W-1:0] o_found_bucket
);

    t_req                req;
    t_stat               stat;
    logic                start;
    logic                res_ready;
    logic                r_out_valid;
    logic [BUCKET_W-1:0] r_out_bucket;

    assign req.op     = i_op;
    assign req.bucket = i_bucket;

    // The walker takes a new beat only when it has finished the last one.
    assign o_ready = stat.idle;
    assign start   = i_valid && stat.idle;

    // The output register may take a new result when empty or being drained.
    assign res_ready = !r_out_valid || i_ready;

    scmt_walker #(
        .BUCKETS(BUCKETS)
    ) u_walker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_req      (req),
        .i_res_ready(res_ready),
        .o_stat     (stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= stat.res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && stat.res_valid) begin
            r_out_bucket <= stat.res;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_found_bucket = r_out_bucket;

endmodule

/* sim/size_class_max_tree_checker.sv */
// Checker for the size-class max tree: watches both channels, keeps its own
// max tree of bucket occupancy and compares every output beat in order.
// Depends on scmt_pkg for the op codes and field widths.
`timescale 1ns / 100ps

module size_class_max_tree_checker
    import scmt_pkg::*;
#(
    parameter int BUCKETS = DEF_BUCKETS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  logic [OP_W-1:0]     i_in_op,
    input  logic [BUCKET_W-1:0] i_in_bucket,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  logic [BUCKET_W-1:0] i_out_found,
    output int                  o_errors,
    output int                  o_pending,
    output int                  o_results
);

    localparam int NODE_CNT  = 2 * BUCKETS - 1;
    localparam int LEAF_BASE = BUCKETS - 1;

    logic [BUCKET_W-1:0] size_tree [0:NODE_CNT-1];
    logic [BUCKET_W-1:0] found_q [$];
    int                  err_cnt = 0;
    int                  res_cnt = 0;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        err_cnt++;
    endtask

    function automatic void mark_bucket(input logic [BUCKET_W-1:0] b);
        int idx;
        idx = LEAF_BASE + int'(b);
        size_tree[idx] = b;
        while (idx > 0) begin
            idx = (idx - 1) / 2;
            if (size_tree[idx] < b) begin
                size_tree[idx] = b;
            end else begin
                break;
            end
        end
    endfunction

    function automatic void clear_bucket(input logic [BUCKET_W-1:0] b);
        int idx;
        logic [BUCKET_W-1:0] lft;
        logic [BUCKET_W-1:0] rgt;
        idx = LEAF_BASE + int'(b);
        size_tree[idx] = '0;
        while (idx > 0) begin
            idx = (idx - 1) / 2;
            if (size_tree[idx] == b) begin
                lft = size_tree[2 * idx + 1];
                rgt = size_tree[2 * idx + 2];
                size_tree[idx] = (lft > rgt) ? lft : rgt;
            end else begin
                break;
            end
        end
    endfunction

    // Descend from the root, going left whenever the left subtree can satisfy the request.
    function automatic logic [BUCKET_W-1:0] find_at_or_above(input logic [BUCKET_W-1:0] req);
        int idx;
        int lft;
        int want;
        want = (req == 0) ? 1 : int'(req);
        if (want >= BUCKETS || int'(size_tree[0]) < want) begin
            return '0;
        end
        idx = 0;
        while (idx < LEAF_BASE) begin
            lft = 2 * idx + 1;
            idx = (int'(size_tree[lft]) >= want) ? lft : lft + 1;
        end
        return (int'(size_tree[idx]) >= want) ? size_tree[idx] : '0;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NODE_CNT; k++) begin
                size_tree[k] = '0;
            end
            found_q.delete();
        end else begin
            // Output side first, so a search taken at this same edge cannot be matched.
            if (i_out_valid && i_out_ready) begin
                if (found_q.size() == 0) begin
                    report_mismatch($sformatf("output beat with nothing expected, found_bucket %0d",
                                              i_out_found));
                end else begin
                    logic [BUCKET_W-1:0] want;
                    want = found_q.pop_front();
                    res_cnt++;
                    if (i_out_found !== want) begin
                        report_mismatch($sformatf("found_bucket %0d, expected %0d",
                                                  i_out_found, want));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                case (i_in_op)
                    OP_MARK: begin
                        if (i_in_bucket != 0 && int'(i_in_bucket) < BUCKETS) begin
                            mark_bucket(i_in_bucket);
                        end
                    end
                    OP_CLEAR: begin
                        if (i_in_bucket != 0 && int'(i_in_bucket) < BUCKETS) begin
                            clear_bucket(i_in_bucket);
                        end
                    end
                    OP_SEARCH: begin
                        found_q.push_back(find_at_or_above(i_in_bucket));
                    end
                    default: begin
                    end
                endcase
            end
        end
        o_pending <= found_q.size();
        o_errors  <= err_cnt;
        o_results <= res_cnt;
    end

endmodule

/* sim/tb.sv */
// Top of the size-class max tree testbench: clock, reset, beat stimulus and verdict.
// Depends on scmt_pkg, size_class_max_tree and size_class_max_tree_checker.
`timescale 1ns / 100ps

module tb
    import scmt_pkg::*;
();

    localparam int BUCKETS       = DEF_BUCKETS;
    localparam int RANDOM_BEATS  = 1250;
    localparam int SEGMENT_BEATS = 50;
    // Worst case per beat is the source gap, the walk and the sink stall, plus
    // the clearing sweep once; this is several times that for the whole run.
    localparam int LIMIT_CYCLES  = 400000;
    // Long enough for any mark, clear or search still inside the block to finish.
    localparam int SETTLE_CYCLES = 24;

    // The fourth op code is not used by the block; it must change nothing.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    logic                i_clk    = 1'b0;
    logic                i_rst_n  = 1'b0;
    logic                i_valid  = 1'b0;
    logic [OP_W-1:0]     i_op     = OP_MARK;
    logic [BUCKET_W-1:0] i_bucket = '0;
    logic                i_ready  = 1'b0;
    logic                o_ready;
    logic                o_valid;
    logic [BUCKET_W-1:0] o_found_bucket;

    int fail_cnt;
    int pending_cnt;
    int result_cnt;
    int cycle_cnt = 0;

    int n_mark   = 0;
    int n_clear  = 0;
    int n_search = 0;
    int n_unused = 0;

    // Idle knobs. The sink knob is read by another process, so it is only
    // changed with a nonblocking assignment at a clock edge.
    bit src_idle_on  = 1'b1;
    bit sink_idle_on = 1'b1;
    int sink_hold    = 0;

    always #10 i_clk = ~i_clk;

    size_class_max_tree #(
        .BUCKETS(BUCKETS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_op           (i_op),
        .i_bucket       (i_bucket),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_found_bucket (o_found_bucket)
    );

    size_class_max_tree_checker #(
        .BUCKETS(BUCKETS)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_in_ready  (o_ready),
        .i_in_op     (i_op),
        .i_in_bucket (i_bucket),
        .i_out_valid (o_valid),
        .i_out_ready (i_ready),
        .i_out_found (o_found_bucket),
        .o_errors    (fail_cnt),
        .o_pending   (pending_cnt),
        .o_results   (result_cnt)
    );

    // The receiver draws a stall for every output beat it takes. A draw of zero
    // keeps ready high, so back-to-back results are taken without a gap.
    always @(posedge i_clk) begin : sink_proc
        int draw;
        if (!i_rst_n) begin
            i_ready   <= 1'b0;
            sink_hold <= $urandom_range(10, 0);
        end else if (i_ready && o_valid) begin
            draw = sink_idle_on ? $urandom_range(10, 0) : 0;
            sink_hold <= draw;
            if (draw != 0) begin
                i_ready <= 1'b0;
            end
        end else if (!i_ready) begin
            if (sink_hold <= 1) begin
                i_ready <= 1'b1;
            end else begin
                sink_hold <= sink_hold - 1;
            end
        end
    end

    // Hard stop in case the block hangs on either handshake.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles with %0d results outstanding",
                     cycle_cnt, pending_cnt);
            $display("status: fail");
            $finish;
        end
    end

    // Present one input beat and return at the edge where it is taken. The
    // caller is always at a rising edge. With no gap the next payload is driven
    // at the same edge that took the previous one, so valid never drops.
    task automatic send_beat(input logic [OP_W-1:0] op, input logic [BUCKET_W-1:0] bkt);
        int gap;
        gap = src_idle_on ? $urandom_range(10, 0) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_op     <= op;
        i_bucket <= bkt;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        case (op)
            OP_MARK:   n_mark++;
            OP_CLEAR:  n_clear++;
            OP_SEARCH: n_search++;
            default:   n_unused++;
        endcase
    endtask

    // Stop sending until every predicted result has come out, then give the
    // block time to finish any mark or clear still climbing the tree.
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_cnt != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int                  counted;
        int                  mark_pct;
        int                  base;
        int                  pick;
        bit                  narrow;
        bit                  paused;
        logic [OP_W-1:0]     op;
        logic [BUCKET_W-1:0] bkt;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed beats. The block sweeps its node memory after reset; the
        // first beat simply waits for ready through that sweep.
        send_beat(OP_SEARCH, 6'd0);    // empty tree answers none
        send_beat(OP_SEARCH, 6'd63);
        send_beat(OP_MARK,   6'd0);    // bucket zero can never become non-empty
        send_beat(OP_SEARCH, 6'd0);
        send_beat(OP_MARK,   6'd63);   // highest bucket
        send_beat(OP_SEARCH, 6'd0);    // search from zero acts as search from one
        send_beat(OP_SEARCH, 6'd63);
        send_beat(OP_MARK,   6'd1);    // lowest real bucket
        send_beat(OP_SEARCH, 6'd0);
        send_beat(OP_SEARCH, 6'd2);
        send_beat(OP_CLEAR,  6'd1);
        send_beat(OP_SEARCH, 6'd1);
        send_beat(OP_CLEAR,  6'd0);    // clear of bucket zero is ignored
        send_beat(OP_UNUSED, 6'd63);   // unused op must leave the tree alone
        send_beat(OP_MARK,   6'd32);
        send_beat(OP_MARK,   6'd32);   // repeated mark changes nothing
        send_beat(OP_SEARCH, 6'd33);
        send_beat(OP_CLEAR,  6'd63);
        send_beat(OP_CLEAR,  6'd63);   // repeated clear changes nothing
        send_beat(OP_SEARCH, 6'd33);
        send_beat(OP_SEARCH, 6'd32);
        send_beat(OP_MARK,   6'd31);
        send_beat(OP_CLEAR,  6'd32);   // root must fall back to the sibling subtree
        send_beat(OP_SEARCH, 6'd1);
        send_beat(OP_SEARCH, 6'd32);
        wait_drained();

        // Random segments. Each segment picks a mark/clear balance so the tree
        // swings between dense and sparse, and sometimes confines buckets to a
        // narrow window so marks and clears keep hitting the same subtrees.
        counted = 0;
        paused  = 1'b0;
        while (counted < RANDOM_BEATS) begin
            mark_pct     = $urandom_range(85, 15);
            narrow       = ($urandom_range(2, 0) == 0);
            base         = $urandom_range(56, 0);
            src_idle_on  = ($urandom_range(3, 0) != 0);
            sink_idle_on <= ($urandom_range(3, 0) != 0);
            repeat (SEGMENT_BEATS) begin
                pick = $urandom_range(99, 0);
                if (narrow) begin
                    bkt = BUCKET_W'(base + $urandom_range(7, 0));
                end else begin
                    bkt = BUCKET_W'($urandom_range(63, 0));
                end
                if (pick < 4) begin
                    op = OP_UNUSED;
                end else if (pick < 40) begin
                    op = OP_SEARCH;
                end else if ($urandom_range(99, 0) < mark_pct) begin
                    op = OP_MARK;
                end else begin
                    op = OP_CLEAR;
                end
                send_beat(op, bkt);
                counted++;
            end
            if (!paused && counted >= RANDOM_BEATS / 2) begin
                wait_drained();
                paused = 1'b1;
            end
        end

        wait_drained();

        $display("covered %0d marks, %0d clears, %0d searches and %0d unused-op beats",
                 n_mark, n_clear, n_search, n_unused);
        $display("%0d search results compared against the predicted tree", result_cnt);
        if (fail_cnt == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
